[hdl/fzy_pkg.sv]
`default_nettype none
package fzy_pkg;

  localparam int unsigned MEMB_FRAC_BITS_DEF = 8;
  localparam int unsigned TEMP_W = 8;
  localparam int unsigned RH_W   = 7;
  localparam int unsigned FAN_W  = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned N_MB = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_T_COLD_END  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_MID       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T_HOT_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H_DRY_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H_MID       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_H_WET_START = 3'd5;

  localparam logic [TEMP_W-1:0] RST_T_COLD_END  = 8'd15;
  localparam logic [TEMP_W-1:0] RST_T_MID       = 8'd20;
  localparam logic [TEMP_W-1:0] RST_T_HOT_START = 8'd25;
  localparam logic [RH_W-1:0]   RST_H_DRY_END   = 7'd60;
  localparam logic [RH_W-1:0]   RST_H_MID       = 7'd70;
  localparam logic [RH_W-1:0]   RST_H_WET_START = 7'd80;

  // membership lanes: temperature columns then humidity rows
  localparam int unsigned MB_COLD   = 0;
  localparam int unsigned MB_MILD   = 1;
  localparam int unsigned MB_HOT    = 2;
  localparam int unsigned MB_WET    = 3;
  localparam int unsigned MB_NORMAL = 4;
  localparam int unsigned MB_DRY    = 5;

  // rows wet, normal, dry; columns cold, mild, hot
  localparam logic [FAN_W-1:0] SPEED [3][3] = '{
    '{7'd0,  7'd10, 7'd30},
    '{7'd25, 7'd50, 7'd75},
    '{7'd50, 7'd75, 7'd100}
  };

  typedef enum logic [1:0] {MB_ZERO, MB_ONE, MB_SLOPE} mb_cls_t;

  typedef struct packed {
    mb_cls_t    cls;
    logic [7:0] delta;
    logic [7:0] span;
  } mb_req_t;

  typedef struct packed {
    logic [TEMP_W-1:0] t_cold_end;
    logic [TEMP_W-1:0] t_mid;
    logic [TEMP_W-1:0] t_hot_start;
    logic [RH_W-1:0]   h_dry_end;
    logic [RH_W-1:0]   h_mid;
    logic [RH_W-1:0]   h_wet_start;
  } fzy_cfg_t;

  function automatic mb_req_t low_sh(input logic [7:0] x, input logic [7:0] lo,
                                     input logic [7:0] mid);
    mb_req_t r;
    r.delta = mid - x;
    r.span  = mid - lo;
    if (x <= lo) r.cls = MB_ONE;
    else if (x >= mid) r.cls = MB_ZERO;
    else r.cls = MB_SLOPE;
    return r;
  endfunction

  function automatic mb_req_t high_sh(input logic [7:0] x, input logic [7:0] mid,
                                      input logic [7:0] hi);
    mb_req_t r;
    r.delta = x - mid;
    r.span  = hi - mid;
    if (x >= hi) r.cls = MB_ONE;
    else if (x <= mid) r.cls = MB_ZERO;
    else r.cls = MB_SLOPE;
    return r;
  endfunction

  function automatic mb_req_t tri_mb(input logic [7:0] x, input logic [7:0] lo,
                                     input logic [7:0] mid, input logic [7:0] hi);
    mb_req_t r;
    r.cls   = MB_SLOPE;
    r.delta = x - lo;
    r.span  = mid - lo;
    if (x == mid) begin
      r.cls = MB_ONE;
    end else if (x < mid) begin
      if (x <= lo) r.cls = MB_ZERO;
    end else begin
      r.delta = hi - x;
      r.span  = hi - mid;
      if (x >= hi) r.cls = MB_ZERO;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/fzy_fifo.sv]
`default_nettype none
module fzy_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      rdata
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_r [DEPTH];
  logic [AW:0]  wptr_r, rptr_r;
  logic         do_push, do_pop;

  assign full    = (wptr_r[AW] != rptr_r[AW]) && (wptr_r[AW-1:0] == rptr_r[AW-1:0]);
  assign empty   = (wptr_r == rptr_r);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r[AW-1:0]] <= wdata;
  end
endmodule
`default_nettype wire

[hdl/fzy_div.sv]
`default_nettype none
module fzy_div #(
  parameter int unsigned NUM_W  = 16,
  parameter int unsigned DEN_W  = 8,
  parameter int unsigned Q_W    = 8,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic [Q_W-1:0]         q_o,
  output logic [SIDE_W-1:0]      side_o
);
  // restoring division, one quotient bit per stage, msb first
  localparam int unsigned CW = NUM_W + DEN_W + Q_W;

  logic [NUM_W-1:0]  rem_p  [Q_W+1];
  logic [DEN_W-1:0]  den_p  [Q_W+1];
  logic [Q_W-1:0]    q_p    [Q_W+1];
  logic [SIDE_W-1:0] side_p [Q_W+1];

  assign rem_p[0]  = num_i;
  assign den_p[0]  = den_i;
  assign q_p[0]    = '0;
  assign side_p[0] = side_i;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int unsigned SH = Q_W - 1 - i;
    logic [CW-1:0]     dsh;
    logic              take;
    logic [CW-1:0]     diff;
    logic [NUM_W-1:0]  rem_r;
    logic [DEN_W-1:0]  den_r;
    logic [Q_W-1:0]    q_r;
    logic [SIDE_W-1:0] side_r;

    assign dsh  = CW'(den_p[i]) << SH;
    assign take = CW'(rem_p[i]) >= dsh;
    assign diff = CW'(rem_p[i]) - dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= take ? diff[NUM_W-1:0] : rem_p[i];
        den_r  <= den_p[i];
        q_r    <= q_p[i] | (Q_W'(take) << SH);
        side_r <= side_p[i];
      end
    end

    assign rem_p[i+1]  = rem_r;
    assign den_p[i+1]  = den_r;
    assign q_p[i+1]    = q_r;
    assign side_p[i+1] = side_r;
  end

  assign q_o    = q_p[Q_W];
  assign side_o = side_p[Q_W];
endmodule
`default_nettype wire

[hdl/fzy_front.sv]
`default_nettype none
module fzy_front
  import fzy_pkg::*;
(
  input  wire fzy_cfg_t          cfg,
  input  wire logic [TEMP_W-1:0] temperature,
  input  wire logic [RH_W-1:0]   humidity,
  output mb_req_t [N_MB-1:0]     req
);
  logic [7:0] h, dry_end, mid, wet_start;

  assign h         = 8'(humidity);
  assign dry_end   = 8'(cfg.h_dry_end);
  assign mid       = 8'(cfg.h_mid);
  assign wet_start = 8'(cfg.h_wet_start);

  always_comb begin
    req[MB_COLD]   = low_sh(temperature, cfg.t_cold_end, cfg.t_mid);
    req[MB_MILD]   = tri_mb(temperature, cfg.t_cold_end, cfg.t_mid, cfg.t_hot_start);
    req[MB_HOT]    = high_sh(temperature, cfg.t_mid, cfg.t_hot_start);
    req[MB_WET]    = high_sh(h, mid, wet_start);
    req[MB_NORMAL] = tri_mb(h, dry_end, mid, wet_start);
    req[MB_DRY]    = low_sh(h, dry_end, mid);
  end
endmodule
`default_nettype wire

[hdl/fzy_back.sv]
`default_nettype none
module fzy_back
  import fzy_pkg::*;
#(
  parameter int unsigned MEMBERSHIP_FRAC_BITS = MEMB_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mb_req_t [N_MB-1:0] req,
  input  wire logic               req_vld,
  output logic                    req_take,
  output logic                    res_vld,
  output logic [FAN_W-1:0]        res_speed,
  input  wire logic               res_full
);
  localparam int unsigned F     = MEMBERSHIP_FRAC_BITS;
  localparam int unsigned MW    = F + 1;
  localparam int unsigned PW    = MW + FAN_W;
  localparam int unsigned RNW   = F + 9;
  localparam int unsigned RDW   = F + 2;
  localparam int unsigned NUMW  = F + 10;
  localparam int unsigned DENW  = F + 4;
  localparam int unsigned LAT   = F + 3 + FAN_W;
  localparam logic [MW-1:0] ONE = MW'(1) << F;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [MW-1:0]  mval [N_MB];

  assign en       = !vld_r[LAT-1] || !res_full;
  assign req_take = en && req_vld;
  assign res_vld  = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], req_take};
    end
  end

  // membership slopes
  for (genvar k = 0; k < N_MB; k++) begin : g_mb
    logic [F-1:0] q;
    logic [1:0]   side;

    fzy_div #(.NUM_W(8 + F), .DEN_W(8), .Q_W(F), .SIDE_W(2)) u_div (
      .clk(clk), .en(en),
      .num_i({req[k].delta, F'(0)}), .den_i(req[k].span), .side_i(req[k].cls),
      .q_o(q), .side_o(side)
    );

    always_comb begin
      case (mb_cls_t'(side))
        MB_ONE:   mval[k] = ONE;
        MB_ZERO:  mval[k] = '0;
        MB_SLOPE: mval[k] = MW'(q);
        default:  mval[k] = '0;
      endcase
    end
  end

  // rule strengths and weighted speeds
  logic [PW-1:0]   prod_r [9];
  logic [MW-1:0]   w_r    [9];
  logic [RNW-1:0]  rnum_r [3];
  logic [RDW-1:0]  rden_r [3];
  logic [NUMW-1:0] num_r;
  logic [DENW-1:0] den_r;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic [MW-1:0] w;
      assign w = (mval[MB_WET + i] < mval[MB_COLD + j]) ? mval[MB_WET + i] : mval[MB_COLD + j];
      always_ff @(posedge clk) begin
        if (en) begin
          w_r[i*3+j]    <= w;
          prod_r[i*3+j] <= PW'(w) * PW'(SPEED[i][j]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rnum_r[i] <= RNW'(prod_r[i*3]) + RNW'(prod_r[i*3+1]) + RNW'(prod_r[i*3+2]);
        rden_r[i] <= RDW'(w_r[i*3]) + RDW'(w_r[i*3+1]) + RDW'(w_r[i*3+2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= NUMW'(rnum_r[0]) + NUMW'(rnum_r[1]) + NUMW'(rnum_r[2]);
      den_r <= DENW'(rden_r[0]) + DENW'(rden_r[1]) + DENW'(rden_r[2]);
    end
  end

  // weighted average, quotient never exceeds the top table speed
  logic [FAN_W-1:0] avg;
  logic             zero_w;

  fzy_div #(.NUM_W(NUMW), .DEN_W(DENW), .Q_W(FAN_W), .SIDE_W(1)) u_avg (
    .clk(clk), .en(en),
    .num_i(num_r), .den_i(den_r), .side_i(den_r == '0),
    .q_o(avg), .side_o(zero_w)
  );

  assign res_speed = zero_w ? '0 : avg;
endmodule
`default_nettype wire

[hdl/fuzzy_fan_speed_controller_unit.sv]
`default_nettype none
// fuzzy fan speed controller: each temperature/humidity word yields one fan speed word
// (0..100 percent), the floored weighted average of a 3x3 rule table whose rule strengths
// are the minimum of a temperature membership (cold, mild, hot) and a humidity membership
// (wet, normal, dry) placed by six breakpoint registers; zero total strength gives 0.
// a word is accepted every cycle while full is low; the path runs through the bit-per-stage
// membership dividers (MEMBERSHIP_FRAC_BITS stages), three rule and summing stages and the
// 7-stage averaging divider. a 4-entry queue sits between the
// classifier and the arithmetic pipeline and a 2-entry queue holds finished words, so
// either side can stall. configuration writes always complete (cfg_ready is high);
// indexes above five are ignored. write configuration only while the block is idle.
module fuzzy_fan_speed_controller_unit
  import fzy_pkg::*;
#(
  parameter int unsigned MEMBERSHIP_FRAC_BITS = MEMB_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input words
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [TEMP_W-1:0]     in_temperature,
  input  wire logic [RH_W-1:0]       in_humidity,
  // result words
  output logic                       empty,
  input  wire logic                  pop,
  output logic [FAN_W-1:0]           out_fan_speed,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int unsigned REQ_W = $bits(mb_req_t) * N_MB;

  fzy_cfg_t cfg_r;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // breakpoint registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.t_cold_end  <= RST_T_COLD_END;
      cfg_r.t_mid       <= RST_T_MID;
      cfg_r.t_hot_start <= RST_T_HOT_START;
      cfg_r.h_dry_end   <= RST_H_DRY_END;
      cfg_r.h_mid       <= RST_H_MID;
      cfg_r.h_wet_start <= RST_H_WET_START;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_T_COLD_END:  cfg_r.t_cold_end  <= cfg_wdata;
        REG_T_MID:       cfg_r.t_mid       <= cfg_wdata;
        REG_T_HOT_START: cfg_r.t_hot_start <= cfg_wdata;
        REG_H_DRY_END:   cfg_r.h_dry_end   <= cfg_wdata[RH_W-1:0];
        REG_H_MID:       cfg_r.h_mid       <= cfg_wdata[RH_W-1:0];
        REG_H_WET_START: cfg_r.h_wet_start <= cfg_wdata[RH_W-1:0];
        default: ;
      endcase
    end
  end

  // front: classify each membership as zero, one or slope
  mb_req_t [N_MB-1:0] req_in, req_q;
  logic               q_empty, q_take;
  logic [REQ_W-1:0]   q_rdata;

  fzy_front u_front (
    .cfg(cfg_r), .temperature(in_temperature), .humidity(in_humidity), .req(req_in)
  );

  fzy_fifo #(.W(REQ_W), .DEPTH(4)) u_req_q (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wdata(REQ_W'(req_in)), .full(full),
    .pop(q_take), .empty(q_empty), .rdata(q_rdata)
  );

  assign req_q = q_rdata;

  // back: divide, combine rules, average
  logic             res_vld, res_full;
  logic [FAN_W-1:0] res_speed;

  fzy_back #(.MEMBERSHIP_FRAC_BITS(MEMBERSHIP_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .req(req_q), .req_vld(!q_empty), .req_take(q_take),
    .res_vld(res_vld), .res_speed(res_speed), .res_full(res_full)
  );

  // finished words wait here for the consumer
  fzy_fifo #(.W(FAN_W), .DEPTH(2)) u_res_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_vld), .wdata(res_speed), .full(res_full),
    .pop(pop), .empty(empty), .rdata(out_fan_speed)
  );
endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fzy_pkg::*;

  localparam int unsigned FRAC = MEMB_FRAC_BITS_DEF;
  localparam int unsigned LATENCY = FRAC + 10 + 8;
  localparam longint CYCLE_LIMIT = 400000;

  // fixed-point value of full membership
  localparam longint unsigned ONE = 64'd1 << FRAC;

  // scoreboard: breakpoint register file as the block should hold it, and the speeds still due
  class fan_speed_scoreboard;
    fzy_cfg_t regs;
    logic [FAN_W-1:0] pending_speeds[$];
    int errors;

    function void reset_regs();
      regs.t_cold_end  = RST_T_COLD_END;
      regs.t_mid       = RST_T_MID;
      regs.t_hot_start = RST_T_HOT_START;
      regs.h_dry_end   = RST_H_DRY_END;
      regs.h_mid       = RST_H_MID;
      regs.h_wet_start = RST_H_WET_START;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_T_COLD_END:  regs.t_cold_end  = val;
        REG_T_MID:       regs.t_mid       = val;
        REG_T_HOT_START: regs.t_hot_start = val;
        REG_H_DRY_END:   regs.h_dry_end   = val[RH_W-1:0];
        REG_H_MID:       regs.h_mid       = val[RH_W-1:0];
        REG_H_WET_START: regs.h_wet_start = val[RH_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned falling(longint unsigned x, lo, mid);
      if (x <= lo) return ONE;
      if (x >= mid) return 0;
      return ((mid - x) * ONE) / (mid - lo);
    endfunction

    function longint unsigned rising(longint unsigned x, mid, hi);
      if (x >= hi) return ONE;
      if (x <= mid) return 0;
      return ((x - mid) * ONE) / (hi - mid);
    endfunction

    function longint unsigned peak(longint unsigned x, lo, mid, hi);
      if (x == mid) return ONE;
      if (x < mid) begin
        if (x <= lo) return 0;
        return ((x - lo) * ONE) / (mid - lo);
      end
      if (x >= hi) return 0;
      return ((hi - x) * ONE) / (hi - mid);
    endfunction

    // note one accepted sample and queue its fan speed
    function void note_sample(logic [TEMP_W-1:0] t, logic [RH_W-1:0] h);
      longint unsigned col[3], row[3], w, num, den;
      num = 0;
      den = 0;
      col[0] = falling(t, regs.t_cold_end, regs.t_mid);
      col[1] = peak(t, regs.t_cold_end, regs.t_mid, regs.t_hot_start);
      col[2] = rising(t, regs.t_mid, regs.t_hot_start);
      row[0] = rising(h, regs.h_mid, regs.h_wet_start);
      row[1] = peak(h, regs.h_dry_end, regs.h_mid, regs.h_wet_start);
      row[2] = falling(h, regs.h_dry_end, regs.h_mid);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          w = row[i] < col[j] ? row[i] : col[j];
          num += w * SPEED[i][j];
          den += w;
        end
      pending_speeds.push_back(den == 0 ? '0 : FAN_W'(num / den));
    endfunction

    function void check_speed(logic [FAN_W-1:0] got);
      logic [FAN_W-1:0] want;
      if (pending_speeds.size() == 0) begin
        $error("fan_speed word with nothing pending: %0d", got);
        errors++;
        return;
      end
      want = pending_speeds.pop_front();
      if (got !== want) begin
        $error("fan_speed mismatch: expected %0d actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [TEMP_W-1:0] in_temperature = '0;
  logic [RH_W-1:0] in_humidity = '0;
  logic empty;
  logic pop = 1'b0;
  logic [FAN_W-1:0] out_fan_speed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  fan_speed_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  always #5 clk = ~clk;

  fuzzy_fan_speed_controller_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_temperature(in_temperature), .in_humidity(in_humidity),
    .empty(empty), .pop(pop), .out_fan_speed(out_fan_speed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // receiver: random pop, checks each accepted word at the edge
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_speed(out_fan_speed);
    pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // offer one sample, with random idle cycles before it
  task automatic send_sample(logic [TEMP_W-1:0] t, logic [RH_W-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_temperature <= t;
    in_humidity <= h;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_sample(t, h);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every pending word has come back, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    while (sb.pending_speeds.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_all(logic [7:0] tc, tm, th, hd, hm, hw);
    write_cfg(REG_T_COLD_END, tc);
    write_cfg(REG_T_MID, tm);
    write_cfg(REG_T_HOT_START, th);
    write_cfg(REG_H_DRY_END, hd);
    write_cfg(REG_H_MID, hm);
    write_cfg(REG_H_WET_START, hw);
  endtask

  // random sample, biased toward the breakpoints so slopes get hit
  task automatic random_sample();
    logic [TEMP_W-1:0] t;
    logic [RH_W-1:0] h;
    t = $urandom_range(3) == 0 ? TEMP_W'($urandom) :
        TEMP_W'(sb.regs.t_cold_end + $urandom_range(20) - 5 +
                $urandom_range(1) * (sb.regs.t_hot_start - sb.regs.t_cold_end));
    h = $urandom_range(3) == 0 ? RH_W'($urandom) :
        RH_W'(sb.regs.h_dry_end + $urandom_range(30) - 5);
    send_sample(t, h);
  endtask

  initial begin
    sb.reset_regs();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and each membership region at reset breakpoints
    send_sample(8'd0, 7'd0);
    send_sample(8'd255, 7'd127);
    send_sample(8'd255, 7'd0);
    send_sample(8'd0, 7'd127);
    send_sample(8'd15, 7'd60);
    send_sample(8'd20, 7'd70);
    send_sample(8'd25, 7'd80);
    send_sample(8'd17, 7'd63);
    send_sample(8'd23, 7'd77);
    send_sample(8'd170, 7'd85);
    drain();

    // equal breakpoints: zero spans must never divide
    write_all(8'd30, 8'd30, 8'd30, 8'd50, 8'd50, 8'd50);
    send_sample(8'd29, 7'd49);
    send_sample(8'd30, 7'd50);
    send_sample(8'd31, 7'd51);
    drain();

    // out of order breakpoints, and an ignored index
    write_all(8'd200, 8'd100, 8'd0, 8'd127, 8'd64, 8'd0);
    write_cfg(3'd6, 8'hAA);
    write_cfg(3'd7, 8'h55);
    send_sample(8'd50, 7'd30);
    send_sample(8'd100, 7'd64);
    send_sample(8'd150, 7'd100);
    send_sample(8'd255, 7'd127);
    drain();

    // full-range breakpoints
    write_all(8'd0, 8'd128, 8'd255, 8'd0, 8'd64, 8'd127);
    send_sample(8'd1, 7'd1);
    send_sample(8'd254, 7'd126);
    send_sample(8'd128, 7'd64);
    drain();

    // back-pressure: receiver holds off while the sender keeps pushing
    hold_off = 1'b1;
    fork
      begin
        int n;
        n = 0;
        while (n < 400) begin
          @(posedge clk);
          n++;
        end
        hold_off = 1'b0;
      end
      begin
        for (int k = 0; k < 30; k++) random_sample();
        push <= 1'b0;
        @(posedge clk);
      end
    join
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 11) write_all(8'd255, 8'd255, 8'd255, 8'd127, 8'd127, 8'd127);
      else if (ph % 3 == 0) sb.reset_regs();
      if (ph % 3 == 0)
        write_all(RST_T_COLD_END, RST_T_MID, RST_T_HOT_START,
                  8'(RST_H_DRY_END), 8'(RST_H_MID), 8'(RST_H_WET_START));
      else if (ph != 11)
        write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(127)),
                  8'($urandom_range(127)), 8'($urandom_range(127)));
      for (int k = 0; k < 150; k++) random_sample();
      drain();
    end

    if (sb.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
